// File: src/xcfr_pkg.sv
package xcfr_pkg;

   // Frame layout
   localparam logic [7:0] START_BYTE_RESET = 8'hB7;
   localparam int unsigned HEADER_LEN = 6;
   localparam logic [8:0] CHECK_POS = 9'd5;
   localparam logic [8:0] RESV_POS = 9'd2;
   localparam logic [8:0] COUNT_POS = 9'd4;
   localparam int unsigned RESV_BIT = 7;

   // Closing status codes
   localparam logic [2:0] ST_BUSY = 3'd0;
   localparam logic [2:0] ST_OK = 3'd1;
   localparam logic [2:0] ST_HDR_BAD = 3'd2;
   localparam logic [2:0] ST_RESV = 3'd3;
   localparam logic [2:0] ST_PAY_BAD = 3'd4;

   // Result queue depth (must be at least 4)
   localparam int unsigned RSP_DEPTH = 8;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [8:0] byte_index;
      logic       frame_last;
      logic [2:0] end_status;
   } result_type;

   // Up to two results written into the queue per cycle
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// File: src/xcfr_if.sv
interface xcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface xcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [8:0] byte_index;
   logic       frame_last;
   logic [2:0] end_status;

   modport source (output valid, output out_byte, output byte_index,
                   output frame_last, output end_status, input ready);
   modport sink (input valid, input out_byte, input byte_index,
                 input frame_last, input end_status, output ready);
endinterface

// File: src/xor_checked_frame_receiver_unit.sv
// Start-byte frame receiver with XOR-checked header and payload.
// req_ch carries one received byte per transaction (valid/ready). rsp_ch
// returns one transaction per stored frame byte with its index; the byte
// that closes or aborts a frame has frame_last set and a status: accepted,
// header check bad, reserved bit set, or payload check bad. A bad header
// check byte that equals the start byte yields a second transaction that
// opens a new frame. Non-start bytes seen while hunting yield nothing.
// csr_we/csr_wdata write the start byte; write it only while idle.
// A taken byte is held in the parser's input register and parsed from there;
// its results are written into the queue and offered on rsp_ch from the
// queue's storage registers.
// Throughput: one byte per cycle; the parser stage is a single registered
// pass and results collect in a RSP_DEPTH-entry queue. req_ch.ready drops
// when the queue could not hold the results of the staged byte and a new
// one, so a stalled receiver backs up into req_ch with nothing lost.
// Reset (synchronous, active high) empties the queue, returns the parser to
// hunting and sets the start byte to 0xB7.
module xor_checked_frame_receiver_unit #(
   parameter int unsigned RSP_DEPTH = xcfr_pkg::RSP_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   xcfr_req_if.sink   req_ch,
   xcfr_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);

   logic [7:0]           start_byte_ff, start_byte_in;
   logic                 stage_valid;
   logic                 in_take;
   logic [CNT_W-1:0]     level;
   logic [CNT_W:0]       room_need;
   xcfr_pkg::push_type   push;
   xcfr_pkg::result_type head;

   // Start byte register
   assign start_byte_in = csr_we ? csr_wdata : start_byte_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= xcfr_pkg::START_BYTE_RESET;
      end else begin
         start_byte_ff <= start_byte_in;
      end
   end

   // Take a byte only if the queue can absorb two results for it and
   // two for the byte already staged
   assign room_need = {1'b0, level} + (stage_valid ? (CNT_W + 1)'(2) : '0);
   assign req_ch.ready = (room_need <= (CNT_W + 1)'(RSP_DEPTH - 2));
   assign in_take = req_ch.valid & req_ch.ready;

   xcfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_take     (in_take),
      .in_byte     (req_ch.in_byte),
      .start_byte  (start_byte_ff),
      .stage_valid (stage_valid),
      .push        (push)
   );

   xcfr_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_ch.ready),
      .pop_valid (rsp_ch.valid),
      .pop_data  (head),
      .level     (level)
   );

   assign rsp_ch.out_byte = head.out_byte;
   assign rsp_ch.byte_index = head.byte_index;
   assign rsp_ch.frame_last = head.frame_last;
   assign rsp_ch.end_status = head.end_status;

endmodule

// File: src/xcfr_parser.sv
module xcfr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_take,
   input  logic [7:0]         in_byte,
   input  logic [7:0]         start_byte,
   output logic               stage_valid,
   output xcfr_pkg::push_type push
);

   logic       stage_valid_ff;
   logic [7:0] stage_byte_ff;

   logic [8:0] pos_ff, pos_in;
   logic [8:0] flen_ff, flen_in;
   logic [7:0] hxor_ff, hxor_in;
   logic [7:0] pxor_ff, pxor_in;
   logic [7:0] pcount_ff, pcount_in;
   logic       resv_ff, resv_in;

   logic [7:0] b;
   logic [8:0] pos_inc;

   assign b = stage_byte_ff;
   assign pos_inc = pos_ff + 9'd1;
   assign stage_valid = stage_valid_ff;

   // Input register: every accepted byte is parsed in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= in_take;
      end
      stage_byte_ff <= in_byte;
   end

   // Frame parse of the staged byte
   always_comb begin
      pos_in = pos_ff;
      flen_in = flen_ff;
      hxor_in = hxor_ff;
      pxor_in = pxor_ff;
      pcount_in = pcount_ff;
      resv_in = resv_ff;
      push.count = 2'd0;
      push.first = '{out_byte: b, byte_index: pos_ff, frame_last: 1'b0,
                     end_status: xcfr_pkg::ST_BUSY};
      push.second = '{out_byte: b, byte_index: 9'd0, frame_last: 1'b0,
                      end_status: xcfr_pkg::ST_BUSY};
      if (stage_valid_ff) begin
         if (pos_ff == 9'd0) begin
            // hunting for the start byte
            if (b == start_byte) begin
               flen_in = 9'd0;
               hxor_in = 8'd0;
               pxor_in = 8'd0;
               pcount_in = 8'd0;
               resv_in = 1'b0;
               pos_in = 9'd1;
               push.count = 2'd1;
            end
         end else if (pos_ff < xcfr_pkg::CHECK_POS) begin
            // header bytes one to four
            hxor_in = hxor_ff ^ b;
            if (pos_ff == xcfr_pkg::RESV_POS) begin
               resv_in = b[xcfr_pkg::RESV_BIT];
            end
            if (pos_ff == xcfr_pkg::COUNT_POS) begin
               pcount_in = b;
            end
            pos_in = pos_inc;
            push.count = 2'd1;
         end else if (pos_ff == xcfr_pkg::CHECK_POS) begin
            // header check byte
            push.count = 2'd1;
            if (b != hxor_ff) begin
               push.first.frame_last = 1'b1;
               push.first.end_status = xcfr_pkg::ST_HDR_BAD;
               pos_in = 9'd0;
               flen_in = 9'd0;
               hxor_in = 8'd0;
               pxor_in = 8'd0;
               pcount_in = 8'd0;
               resv_in = 1'b0;
               if (b == start_byte) begin
                  pos_in = 9'd1;
                  push.count = 2'd2;
               end
            end else if (pcount_ff == 8'd0) begin
               push.first.frame_last = 1'b1;
               push.first.end_status = resv_ff ? xcfr_pkg::ST_RESV : xcfr_pkg::ST_OK;
               pos_in = 9'd0;
               flen_in = 9'd0;
               hxor_in = 8'd0;
               pxor_in = 8'd0;
               pcount_in = 8'd0;
               resv_in = 1'b0;
            end else begin
               flen_in = 9'(xcfr_pkg::HEADER_LEN + 1) + {1'b0, pcount_ff};
               pos_in = pos_inc;
            end
         end else begin
            // payload and trailing check byte
            push.count = 2'd1;
            if (pos_inc >= flen_ff) begin
               push.first.frame_last = 1'b1;
               if (resv_ff) begin
                  push.first.end_status = xcfr_pkg::ST_RESV;
               end else if (b == pxor_ff) begin
                  push.first.end_status = xcfr_pkg::ST_OK;
               end else begin
                  push.first.end_status = xcfr_pkg::ST_PAY_BAD;
               end
               pos_in = 9'd0;
               flen_in = 9'd0;
               hxor_in = 8'd0;
               pxor_in = 8'd0;
               pcount_in = 8'd0;
               resv_in = 1'b0;
            end else begin
               pxor_in = pxor_ff ^ b;
               pos_in = pos_inc;
            end
         end
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 9'd0;
         flen_ff <= 9'd0;
         hxor_ff <= 8'd0;
         pxor_ff <= 8'd0;
         pcount_ff <= 8'd0;
         resv_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         flen_ff <= flen_in;
         hxor_ff <= hxor_in;
         pxor_ff <= pxor_in;
         pcount_ff <= pcount_in;
         resv_ff <= resv_in;
      end
   end

endmodule

// File: src/xcfr_rsp_fifo.sv
module xcfr_rsp_fifo #(
   parameter int unsigned DEPTH = xcfr_pkg::RSP_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  xcfr_pkg::push_type                  push,
   input  logic                                pop_ready,
   output logic                                pop_valid,
   output xcfr_pkg::result_type                pop_data,
   output logic [$clog2(DEPTH + 1) - 1:0]      level
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   xcfr_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
      ptr_step = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign pop_valid = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign pop = pop_valid & pop_ready;
   assign level = count_ff;
   assign wr_ptr_next = ptr_step(wr_ptr_ff);

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_ptr_next;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = ptr_step(wr_ptr_next);
      end
      rd_ptr_in = pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Result storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule
